// ----- design/tcps_pkg.sv -----
`timescale 1ns / 1ps
package tcps_pkg;
  localparam int MaxTemplate = 32;
  localparam int MaxWindow = 256;
  localparam int TapW = $clog2(MaxTemplate);
  localparam int TlenW = 6;
  localparam int WlenW = 9;
  localparam int WcntW = $clog2(MaxWindow + 1);
  localparam int AccW = 48;
  localparam int NumW = AccW + 16;

  localparam logic [0:0] CfgTemplateLength = 1'b0;
  localparam logic [0:0] CfgWindowLength = 1'b1;
  localparam logic KindTemplate = 1'b0;

  typedef struct packed {
    logic kind;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] offset;
    logic signed [31:0] ratio;
    logic [7:0] best_offset;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic signed [AccW-1:0] num;
    logic [AccW-1:0] den;
  } div_req_t;
endpackage

// ----- design/tcps_div.sv -----
`timescale 1ns / 1ps
module tcps_div (
  input  logic clk,
  input  logic rst,
  input  tcps_pkg::div_req_t req,
  output logic done,
  output logic signed [31:0] quot
);
  import tcps_pkg::*;

  // Restoring divider, one quotient bit per cycle over (|num| << 16) / den.
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] dividend;
  logic [AccW:0] rem;
  logic [AccW-1:0] divisor;
  logic neg;
  logic zero;
  logic busy;
  logic [CntW-1:0] cnt;
  logic [AccW:0] trial;
  logic [AccW:0] shifted;
  logic [AccW-1:0] mag;

  assign shifted = {rem[AccW-1:0], dividend[NumW-1]};
  assign trial = shifted - {1'b0, divisor};
  assign mag = req.num[AccW-1] ? AccW'(-req.num) : AccW'(req.num);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
        dividend <= {mag, 16'd0};
        rem <= '0;
        divisor <= req.den;
        neg <= req.num[AccW-1];
        zero <= (req.den == '0);
      end else if (busy) begin
        dividend <= {dividend[NumW-2:0], ~trial[AccW]};
        rem <= trial[AccW] ? shifted : trial;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits accumulate in dividend; saturate on the way out.
  always_comb begin
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      if (dividend > NumW'(64'h8000_0000)) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = -$signed(dividend[31:0]);
      end
    end else if (dividend > NumW'(64'h7FFF_FFFF)) begin
      quot = 32'sh7FFF_FFFF;
    end else begin
      quot = $signed(dividend[31:0]);
    end
  end
endmodule

// ----- design/template_correlation_peak_search.sv -----
`timescale 1ns / 1ps
// Channel  | valid     | stall     | payload
// in       | in_valid  | in_stall  | in_data  (kind, sample)
// out      | out_valid | out_stall | out_data (offset, ratio, best_offset, last)
// A template beat is taken in the idle state. A window beat that yields a correlation
// passes from the accept in the idle state through the shared multiply-accumulate, a
// divider start state and the serial divider, then a post state that posts the
// result; no new beat is taken until the result is posted.
// Reset (rst, synchronous) clears counters and the peak tracker; the sample
// stores are not cleared. A stalled output holds one result while the block
// keeps working; a new result waits only if the output register is full.
module template_correlation_peak_search (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tcps_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output tcps_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import tcps_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac = 3'd1;
  localparam logic [2:0] StDivGo = 3'd2;
  localparam logic [2:0] StDiv = 3'd3;
  localparam logic [2:0] StPost = 3'd4;

  logic [2:0] state;
  logic [TlenW-1:0] template_length;
  logic [WlenW-1:0] window_length;
  logic signed [15:0] template_store [MaxTemplate];
  logic signed [15:0] window_line [MaxTemplate];
  logic [TapW:0] template_count;
  logic [WcntW-1:0] window_count;
  logic signed [31:0] best_ratio;
  logic [7:0] best_position;

  logic [TapW:0] taps;
  logic [WcntW-1:0] flen;
  logic [TapW:0] idx;
  logic signed [AccW-1:0] num;
  logic [AccW-1:0] den;
  logic signed [15:0] t_rd;
  logic signed [15:0] w_rd;
  logic signed [31:0] prod_tw;
  logic [31:0] prod_ww;
  logic prod_ok;
  logic final_flag;
  logic [7:0] cur_offset;
  logic accept;
  logic [WcntW-1:0] wc_new;
  logic div_done;
  logic signed [31:0] quot;
  div_req_t dreq;

  always_comb begin
    taps = (template_length == '0) ? (TapW+1)'(1) :
           (template_length > TlenW'(MaxTemplate)) ? (TapW+1)'(MaxTemplate) :
           (TapW+1)'(template_length);
    flen = (window_length > WlenW'(MaxWindow)) ? WcntW'(MaxWindow) :
           WcntW'(window_length);
  end

  assign in_stall = (state != StIdle);
  assign accept = in_valid && !in_stall;
  assign wc_new = (window_count < WcntW'(MaxWindow)) ? window_count + 1'b1 : window_count;

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        CfgTemplateLength: template_length <= cfg_data[TlenW-1:0];
        CfgWindowLength: window_length <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      template_length <= TlenW'(32);
      window_length <= WlenW'(176);
    end
  end

  // Sample stores: template written at one address, window as a shift line.
  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KindTemplate && template_count < taps) begin
      template_store[template_count[TapW-1:0]] <= in_data.sample;
    end
    if (accept && in_data.kind != KindTemplate) begin
      for (int i = 0; i < MaxTemplate - 1; i++) begin
        window_line[i] <= window_line[i+1];
      end
      window_line[MaxTemplate-1] <= in_data.sample;
    end
  end

  assign t_rd = template_store[idx[TapW-1:0]];
  assign w_rd = window_line[TapW'(MaxTemplate - 32'(taps) + 32'(idx))];

  always_ff @(posedge clk) begin
    prod_tw <= t_rd * w_rd;
    prod_ww <= $unsigned(32'(w_rd) * 32'(w_rd));
  end

  assign dreq.start = (state == StDivGo);
  assign dreq.num = num;
  assign dreq.den = den;

  tcps_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      template_count <= '0;
      window_count <= '0;
      best_ratio <= 32'sh8000_0000;
      best_position <= '0;
      out_valid <= 1'b0;
      prod_ok <= 1'b0;
    end else begin
      // The post state sets the output valid itself.
      if (out_valid && !out_stall && state != StPost) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (accept) begin
            if (in_data.kind == KindTemplate) begin
              if (template_count < taps) template_count <= template_count + 1'b1;
            end else begin
              final_flag <= (wc_new >= flen);
              if (wc_new < WcntW'(taps)) begin
                if (wc_new >= flen) begin
                  template_count <= '0;
                  window_count <= '0;
                  best_ratio <= 32'sh8000_0000;
                  best_position <= '0;
                end else begin
                  window_count <= wc_new;
                end
              end else begin
                window_count <= wc_new;
                cur_offset <= 8'(wc_new - WcntW'(taps));
                idx <= '0;
                num <= '0;
                den <= '0;
                prod_ok <= 1'b0;
                state <= StMac;
              end
            end
          end
        end
        StMac: begin
          // Products are registered, so they arrive in the cycle after their read index.
          if (prod_ok) begin
            num <= num + AccW'(prod_tw);
            den <= den + AccW'(prod_ww);
          end
          prod_ok <= (idx < taps);
          if (idx < taps) begin
            idx <= idx + 1'b1;
          end else begin
            state <= StDivGo;
          end
        end
        StDivGo: state <= StDiv;
        StDiv: begin
          if (div_done) begin
            state <= StPost;
          end
        end
        StPost: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.offset <= cur_offset;
            out_data.ratio <= quot;
            out_data.last <= final_flag;
            out_data.best_offset <= (quot > best_ratio) ? cur_offset : best_position;
            if (final_flag) begin
              template_count <= '0;
              window_count <= '0;
              best_ratio <= 32'sh8000_0000;
              best_position <= '0;
            end else if (quot > best_ratio) begin
              best_ratio <= quot;
              best_position <= cur_offset;
            end
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // The block never takes a beat while a correlation is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !accept) else $error("beat taken while busy");
  // A result is posted only from the post state.
  a_post_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(state) == StPost)) else $error("stray result");
  // The divider finishes only while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == StDiv)) else $error("divider out of step");
endmodule
